/* rtl/assert_macros.svh */
// Assertion macros used by the top level of the background pixel fetcher
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, clocked on i_clk, off during reset
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on i_clk, off during reset
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/tbpf_pkg.sv */
// Types, codes and constants of the background pixel fetcher
`timescale 1ns / 1ps
`default_nettype none

package tbpf_pkg;

    localparam int VMEM_AW      = 14;
    localparam int BANK_DEPTH   = 8192;
    localparam int PAL_DEPTH    = 32;
    localparam int PAL_AW       = 5;
    localparam int COLOR_W      = 15;
    localparam int CFG_AW       = 2;
    localparam int CFG_DW       = 8;

    localparam logic [1:0] REQ_VMEM   = 2'd0;
    localparam logic [1:0] REQ_PAL    = 2'd1;
    localparam logic [1:0] REQ_RENDER = 2'd2;

    localparam logic [CFG_AW-1:0] CFG_SCROLL_X      = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_SCROLL_Y      = 2'd1;
    localparam logic [CFG_AW-1:0] CFG_TILE_UNSIGNED = 2'd2;
    localparam logic [CFG_AW-1:0] CFG_MAP_HIGH      = 2'd3;

    // Top bits of the tile map base 0x1800 within bank 0
    localparam logic [1:0] MAP_BASE_TOP = 2'b11;

    localparam int ATTR_BANK_BIT  = 3;
    localparam int ATTR_XFLIP_BIT = 5;
    localparam int ATTR_YFLIP_BIT = 6;
    localparam int ATTR_PRIO_BIT  = 7;

    typedef struct packed {
        logic [7:0] scroll_x;
        logic [7:0] scroll_y;
        logic       tile_unsigned;
        logic       map_high;
    } t_cfg;

    typedef struct packed {
        logic [1:0]         req;
        logic [VMEM_AW-1:0] mem_addr;
        logic [7:0]         mem_byte;
        logic [PAL_AW-1:0]  pal_slot;
        logic [COLOR_W-1:0] pal_value;
        logic [7:0]         column_x;
        logic [7:0]         line_y;
    } t_req_item;

    typedef struct packed {
        logic [1:0]         req;
        logic [VMEM_AW-1:0] mem_addr;
        logic [7:0]         mem_byte;
        logic [PAL_AW-1:0]  pal_slot;
        logic [COLOR_W-1:0] pal_value;
        logic [2:0]         fine_x;
        logic [2:0]         fine_y;
    } t_carry_b;

    typedef struct packed {
        t_carry_b    carry;
        logic [12:0] map_idx;
    } t_stage_a;

    typedef struct packed {
        t_carry_b   carry;
        logic [7:0] tile;
        logic [7:0] attr;
    } t_stage_b;

    typedef struct packed {
        logic [1:0]         req;
        logic [PAL_AW-1:0]  pal_slot;
        logic [COLOR_W-1:0] pal_value;
        logic [2:0]         bit_sel;
        logic [2:0]         pal_num;
        logic               prio;
    } t_carry_c;

    typedef struct packed {
        t_carry_c   carry;
        logic [7:0] plane_lo;
        logic [7:0] plane_hi;
    } t_stage_c;

    typedef struct packed {
        logic [COLOR_W-1:0] color;
        logic [1:0]         index;
        logic               prio;
    } t_pixel;

endpackage

`default_nettype wire

/* rtl/tbpf_ram.sv */
// Generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps
`default_nettype none

module tbpf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* rtl/tbpf_map_fetch.sv */
// Input stage with scroll, tile map address and map/attribute memory read
`timescale 1ns / 1ps
`default_nettype none

module tbpf_map_fetch (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire tbpf_pkg::t_cfg      i_cfg,
    input  wire logic                i_valid,
    input  wire tbpf_pkg::t_req_item i_item,
    input  wire logic                i_en_a,
    input  wire logic                i_en_b,
    output logic                     o_a_valid,
    output logic                     o_b_valid,
    output tbpf_pkg::t_stage_b       o_b
);

    tbpf_pkg::t_stage_a n_a;
    tbpf_pkg::t_stage_a r_a;
    logic               r_a_valid;
    tbpf_pkg::t_carry_b r_b;
    logic               r_b_valid;
    logic [7:0]         w_px;
    logic [7:0]         w_py;
    logic [7:0]         w_tile;
    logic [7:0]         w_attr;
    logic               w_vmem_wr;

    always_comb begin
        w_px = i_item.column_x + i_cfg.scroll_x;
        w_py = i_item.line_y + i_cfg.scroll_y;
        n_a.carry.req       = i_item.req;
        n_a.carry.mem_addr  = i_item.mem_addr;
        n_a.carry.mem_byte  = i_item.mem_byte;
        n_a.carry.pal_slot  = i_item.pal_slot;
        n_a.carry.pal_value = i_item.pal_value;
        n_a.carry.fine_x    = w_px[2:0];
        n_a.carry.fine_y    = w_py[2:0];
        n_a.map_idx         = {tbpf_pkg::MAP_BASE_TOP, i_cfg.map_high, w_py[7:3], w_px[7:3]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            if (i_en_a) begin
                r_a_valid <= i_valid;
            end
            if (i_en_b) begin
                r_b_valid <= r_a_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en_a) begin
            r_a <= n_a;
        end
        if (i_en_b) begin
            r_b <= r_a.carry;
        end
    end

    assign w_vmem_wr = r_a_valid && (r_a.carry.req == tbpf_pkg::REQ_VMEM) && i_en_b;

    tbpf_ram #(
        .WIDTH (8),
        .DEPTH (tbpf_pkg::BANK_DEPTH)
    ) u_map_bank0 (
        .i_clk   (i_clk),
        .i_we    (w_vmem_wr && !r_a.carry.mem_addr[13]),
        .i_waddr (r_a.carry.mem_addr[12:0]),
        .i_wdata (r_a.carry.mem_byte),
        .i_re    (i_en_b),
        .i_raddr (r_a.map_idx),
        .o_rdata (w_tile)
    );

    tbpf_ram #(
        .WIDTH (8),
        .DEPTH (tbpf_pkg::BANK_DEPTH)
    ) u_map_bank1 (
        .i_clk   (i_clk),
        .i_we    (w_vmem_wr && r_a.carry.mem_addr[13]),
        .i_waddr (r_a.carry.mem_addr[12:0]),
        .i_wdata (r_a.carry.mem_byte),
        .i_re    (i_en_b),
        .i_raddr (r_a.map_idx),
        .o_rdata (w_attr)
    );

    assign o_a_valid = r_a_valid;
    assign o_b_valid = r_b_valid;

    always_comb begin
        o_b.carry = r_b;
        o_b.tile  = w_tile;
        o_b.attr  = w_attr;
    end

endmodule

`default_nettype wire

/* rtl/tbpf_tile_fetch.sv */
// Tile row address with flips and bank, and bitplane memory read
`timescale 1ns / 1ps
`default_nettype none

module tbpf_tile_fetch (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_tile_unsigned,
    input  wire logic               i_b_valid,
    input  wire tbpf_pkg::t_stage_b i_b,
    input  wire logic               i_en_c,
    output logic                    o_c_valid,
    output tbpf_pkg::t_stage_c      o_c
);

    tbpf_pkg::t_carry_c n_c;
    tbpf_pkg::t_carry_c r_c;
    logic               r_c_valid;
    logic [2:0]         w_row;
    logic               w_low_half;
    logic [12:0]        w_pair_idx;
    logic               w_vmem_wr;
    logic [7:0]         w_lo;
    logic [7:0]         w_hi;

    always_comb begin
        w_row      = i_b.attr[tbpf_pkg::ATTR_YFLIP_BIT] ? ~i_b.carry.fine_y : i_b.carry.fine_y;
        w_low_half = !i_tile_unsigned && !i_b.tile[7];
        w_pair_idx = {i_b.attr[tbpf_pkg::ATTR_BANK_BIT], w_low_half, i_b.tile, w_row};
        n_c.req       = i_b.carry.req;
        n_c.pal_slot  = i_b.carry.pal_slot;
        n_c.pal_value = i_b.carry.pal_value;
        n_c.bit_sel   = i_b.attr[tbpf_pkg::ATTR_XFLIP_BIT] ? i_b.carry.fine_x
                                                           : ~i_b.carry.fine_x;
        n_c.pal_num   = i_b.attr[2:0];
        n_c.prio      = i_b.attr[tbpf_pkg::ATTR_PRIO_BIT];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (i_en_c) begin
            r_c_valid <= i_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en_c) begin
            r_c <= n_c;
        end
    end

    assign w_vmem_wr = i_b_valid && (i_b.carry.req == tbpf_pkg::REQ_VMEM) && i_en_c;

    tbpf_ram #(
        .WIDTH (8),
        .DEPTH (tbpf_pkg::BANK_DEPTH)
    ) u_plane_even (
        .i_clk   (i_clk),
        .i_we    (w_vmem_wr && !i_b.carry.mem_addr[0]),
        .i_waddr (i_b.carry.mem_addr[13:1]),
        .i_wdata (i_b.carry.mem_byte),
        .i_re    (i_en_c),
        .i_raddr (w_pair_idx),
        .o_rdata (w_lo)
    );

    tbpf_ram #(
        .WIDTH (8),
        .DEPTH (tbpf_pkg::BANK_DEPTH)
    ) u_plane_odd (
        .i_clk   (i_clk),
        .i_we    (w_vmem_wr && i_b.carry.mem_addr[0]),
        .i_waddr (i_b.carry.mem_addr[13:1]),
        .i_wdata (i_b.carry.mem_byte),
        .i_re    (i_en_c),
        .i_raddr (w_pair_idx),
        .o_rdata (w_hi)
    );

    assign o_c_valid = r_c_valid;

    always_comb begin
        o_c.carry    = r_c;
        o_c.plane_lo = w_lo;
        o_c.plane_hi = w_hi;
    end

endmodule

`default_nettype wire

/* rtl/tbpf_pal_lookup.sv */
// Color index from bitplanes, palette memory and output register
`timescale 1ns / 1ps
`default_nettype none

module tbpf_pal_lookup (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_c_valid,
    input  wire tbpf_pkg::t_stage_c i_c,
    input  wire logic               i_en_d,
    output logic                    o_d_valid,
    output tbpf_pkg::t_pixel        o_pixel
);

    logic [1:0]                   w_index;
    logic [tbpf_pkg::PAL_AW-1:0]  w_pal_raddr;
    logic                         w_pal_wr;
    logic [tbpf_pkg::COLOR_W-1:0] w_color;
    logic                         r_d_valid;
    logic [1:0]                   r_index;
    logic                         r_prio;

    always_comb begin
        w_index     = {i_c.plane_hi[i_c.carry.bit_sel], i_c.plane_lo[i_c.carry.bit_sel]};
        w_pal_raddr = {i_c.carry.pal_num, w_index};
        w_pal_wr    = i_c_valid && (i_c.carry.req == tbpf_pkg::REQ_PAL) && i_en_d;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid <= 1'b0;
        end else if (i_en_d) begin
            r_d_valid <= i_c_valid && (i_c.carry.req == tbpf_pkg::REQ_RENDER);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en_d) begin
            r_index <= w_index;
            r_prio  <= i_c.carry.prio;
        end
    end

    tbpf_ram #(
        .WIDTH (tbpf_pkg::COLOR_W),
        .DEPTH (tbpf_pkg::PAL_DEPTH)
    ) u_palette (
        .i_clk   (i_clk),
        .i_we    (w_pal_wr),
        .i_waddr (i_c.carry.pal_slot),
        .i_wdata (i_c.carry.pal_value),
        .i_re    (i_en_d),
        .i_raddr (w_pal_raddr),
        .o_rdata (w_color)
    );

    assign o_d_valid = r_d_valid;

    always_comb begin
        o_pixel.color = w_color;
        o_pixel.index = r_index;
        o_pixel.prio  = r_prio;
    end

endmodule

`default_nettype wire

/* rtl/tile_background_pixel_fetch.sv */
// Top level of the background pixel fetcher: stream ports, configuration, stage control
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

// Four-stage pipeline that takes one item per cycle unless backed up by a stalled
// output: input register, tile map and attribute read, bitplane read, palette read
// into the output register. A render item's pixel reaches the output through the
// three registered memory reads in sequence. Video and palette writes travel the
// same stages and update each memory at the stage that reads it, so every item
// sees all writes that came before it and none after. Writes give no result, nor
// does request code 3. A stalled output backs the pipeline up one stage at a time,
// so empty stages still fill. Memory contents are undefined until written.
module tile_background_pixel_fetch (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // mem_addr, mem_byte, pal_slot, pal_value, column_x, line_y, zero pad
    input  wire logic [63:0] s_tdata,
    // req_type
    input  wire logic [1:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // pixel_color, color_index, bg_priority, zero pad
    output logic [23:0]      m_tdata,
    input  wire logic        i_cfg_we,
    input  wire logic [tbpf_pkg::CFG_AW-1:0] i_cfg_index,
    input  wire logic [tbpf_pkg::CFG_DW-1:0] i_cfg_data
);

    tbpf_pkg::t_cfg      r_cfg;
    tbpf_pkg::t_req_item w_item;
    tbpf_pkg::t_stage_b  w_b;
    tbpf_pkg::t_stage_c  w_c;
    tbpf_pkg::t_pixel    w_pixel;
    logic                w_a_valid;
    logic                w_b_valid;
    logic                w_c_valid;
    logic                w_d_valid;
    logic                w_en_a;
    logic                w_en_b;
    logic                w_en_c;
    logic                w_en_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                tbpf_pkg::CFG_SCROLL_X:      r_cfg.scroll_x      <= i_cfg_data;
                tbpf_pkg::CFG_SCROLL_Y:      r_cfg.scroll_y      <= i_cfg_data;
                tbpf_pkg::CFG_TILE_UNSIGNED: r_cfg.tile_unsigned <= i_cfg_data[0];
                tbpf_pkg::CFG_MAP_HIGH:      r_cfg.map_high      <= i_cfg_data[0];
                default:                     r_cfg               <= r_cfg;
            endcase
        end
    end

    always_comb begin
        w_item.req       = s_tuser;
        w_item.mem_addr  = s_tdata[13:0];
        w_item.mem_byte  = s_tdata[21:14];
        w_item.pal_slot  = s_tdata[26:22];
        w_item.pal_value = s_tdata[41:27];
        w_item.column_x  = s_tdata[49:42];
        w_item.line_y    = s_tdata[57:50];
    end

    assign w_en_d   = !w_d_valid || m_tready;
    assign w_en_c   = !w_c_valid || w_en_d;
    assign w_en_b   = !w_b_valid || w_en_c;
    assign w_en_a   = !w_a_valid || w_en_b;
    assign s_tready = w_en_a;

    tbpf_map_fetch u_map_fetch (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_valid   (s_tvalid),
        .i_item    (w_item),
        .i_en_a    (w_en_a),
        .i_en_b    (w_en_b),
        .o_a_valid (w_a_valid),
        .o_b_valid (w_b_valid),
        .o_b       (w_b)
    );

    tbpf_tile_fetch u_tile_fetch (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_tile_unsigned (r_cfg.tile_unsigned),
        .i_b_valid       (w_b_valid),
        .i_b             (w_b),
        .i_en_c          (w_en_c),
        .o_c_valid       (w_c_valid),
        .o_c             (w_c)
    );

    tbpf_pal_lookup u_pal_lookup (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_c_valid (w_c_valid),
        .i_c       (w_c),
        .i_en_d    (w_en_d),
        .o_d_valid (w_d_valid),
        .o_pixel   (w_pixel)
    );

    assign m_tvalid = w_d_valid;
    assign m_tdata  = {6'd0, w_pixel.prio, w_pixel.index, w_pixel.color};

    `ASSERT_IMPL(a_full_when_blocked, !s_tready,
        w_a_valid && w_b_valid && w_c_valid && w_d_valid,
        "input held off while a pipeline stage is empty")
    `ASSERT_NEXT(a_render_reaches_out,
        w_c_valid && (w_c.carry.req == tbpf_pkg::REQ_RENDER) && w_en_d,
        m_tvalid, "render item lost before output")
    `ASSERT_NEXT(a_no_result_for_write,
        w_c_valid && (w_c.carry.req != tbpf_pkg::REQ_RENDER) && w_en_d,
        !m_tvalid, "non-render item produced a result")

endmodule

`default_nettype wire
